[rtl/core/fsc_pkg.sv]
// shared types, constants and the sigmoid gate rom for the synapse current core
// no dependencies; the rom contents are built at elaboration by gate_rom_init

package fsc_pkg;

  localparam int GATE_TABLE_DEPTH = 256;
  localparam int IDX_W            = $clog2(GATE_TABLE_DEPTH);
  localparam int FRAC_W           = 24;
  localparam int POS_W            = FRAC_W + IDX_W;
  localparam int GATE_W           = 17;
  localparam int XR_W             = 33;
  localparam int DRIVE_W          = 26;

  localparam logic signed [XR_W-1:0] X_SPAN = XR_W'(64'sd8388608);
  localparam logic [GATE_W-1:0]      GATE_ONE = GATE_W'(65536);

  localparam logic [15:0] COND_RESET  = 16'd4096;
  localparam logic [15:0] REV_RESET   = 16'd0;
  localparam logic [15:0] SLOPE_RESET = 16'd4096;
  localparam logic [15:0] THR_RESET   = 16'd0;

  typedef enum logic [1:0] {
    REG_CONDUCTANCE = 2'd0,
    REG_REVERSAL    = 2'd1,
    REG_GATE_SLOPE  = 2'd2,
    REG_GATE_THRESH = 2'd3
  } cfg_reg_t;

  typedef logic [GATE_W-1:0] gate_rom_t [GATE_TABLE_DEPTH];

  localparam logic [63:0] ONE30 = 64'd1 << 30;

  // unsigned long division, only used while building the rom contents
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem = rem - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // q16 value of 1/(1+exp(x_k)), exp via taylor series of e^(-|x|/16) and four squarings
  function automatic logic [GATE_W-1:0] gate_entry(input int k);
    longint            m;
    logic              nonneg;
    logic [63:0]       am;
    logic [63:0]       g;
    logic [63:0]       term;
    logic [63:0]       e;
    logic [63:0]       den;
    logic [63:0]       q;
    logic signed [63:0] sum;
    m = 16 * longint'(k) - 8 * longint'(GATE_TABLE_DEPTH - 1);
    nonneg = (m >= 0);
    am = nonneg ? 64'(m) : 64'(-m);
    g = udiv64(am << 26, 64'(GATE_TABLE_DEPTH - 1));
    term = ONE30;
    sum = $signed(ONE30);
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * g) >> 30, 64'(i));
      if (i[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    e = 64'(sum);
    for (int j = 0; j < 4; j++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    den = ONE30 + e;
    if (nonneg) begin
      q = udiv64((e << 16) + (den >> 1), den);
    end else begin
      q = udiv64((64'd1 << 46) + (den >> 1), den);
    end
    return GATE_W'(q);
  endfunction

  function automatic gate_rom_t gate_rom_init();
    gate_rom_t rom;
    for (int k = 0; k < GATE_TABLE_DEPTH; k++) begin
      rom[k] = gate_entry(k);
    end
    return rom;
  endfunction

  localparam gate_rom_t GATE_ROM = gate_rom_init();

endpackage

[rtl/core/fast_synapse_current_core.sv]
// synapse current core: rescaled driving force times sigmoid gate times conductance
// depends on fsc_pkg for widths, register codes and the gate rom
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    post/pre voltage, input scale, input offset
// out       output     out_valid/out_ready  synapse current, saturated flag
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// eight register stages, one item per cycle sustained while out_ready is high
// the critical stages are the two signed multipliers at the end and the interpolation multiply
// each stage loads when empty or when the stage after it moves, so bubbles close up on a stall
// synchronous active-low reset clears the valid bits and loads the config registers with their reset values
// cfg_ready is always high

module fast_synapse_current_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_post_voltage,
  input  logic signed [15:0] in_pre_voltage,
  input  logic signed [15:0] in_input_scale,
  input  logic signed [15:0] in_input_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_synapse_current,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  import fsc_pkg::*;

  localparam int NSTG = 8;

  // config registers
  logic signed [15:0] cond_r, rev_r, slope_r, thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cond_r  <= COND_RESET;
      rev_r   <= REV_RESET;
      slope_r <= SLOPE_RESET;
      thr_r   <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CONDUCTANCE: cond_r  <= cfg_data;
        REG_REVERSAL:    rev_r   <= cfg_data;
        REG_GATE_SLOPE:  slope_r <= cfg_data;
        REG_GATE_THRESH: thr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits and per-stage load enables
  logic [NSTG-1:0] v_r, v_nxt, ld, v_up;

  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign v_up     = {v_r[NSTG-2:0], in_valid};
  assign v_nxt    = (ld & v_up) | (~ld & v_r);
  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: presynaptic product and gate argument product
  logic               scale_zero;
  logic signed [15:0] scale_sel, off_sel;
  logic signed [16:0] xdiff;
  logic signed [31:0] s1_vmul_nxt, s1_vmul_r;
  logic signed [15:0] s1_off_r;
  logic signed [XR_W-1:0] s1_xr_nxt, s1_xr_r;

  assign scale_zero  = (in_input_scale == 16'sd0);
  assign scale_sel   = scale_zero ? 16'sd256 : in_input_scale;
  assign off_sel     = scale_zero ? 16'sd0 : in_input_offset;
  assign xdiff       = 17'(thr_r) - 17'(in_post_voltage);
  assign s1_vmul_nxt = scale_sel * in_pre_voltage;
  assign s1_xr_nxt   = XR_W'(slope_r) * XR_W'(xdiff);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_vmul_r <= s1_vmul_nxt;
      s1_off_r  <= off_sel;
      s1_xr_r   <= s1_xr_nxt;
    end
  end

  // stage 2: driving force, table position
  logic signed [31:0]        vshift;
  logic signed [DRIVE_W-1:0] s2_drive_nxt, s2_drive_r;
  logic signed [XR_W-1:0]    xsum;
  logic [FRAC_W:0]           xoff;
  logic [POS_W-1:0]          pos;
  logic                      s2_lo_r, s2_hi_r;
  logic [IDX_W-1:0]          s2_idx_r;
  logic [FRAC_W-1:0]         s2_frac_r;

  assign vshift       = s1_vmul_r >>> 8;
  assign s2_drive_nxt = DRIVE_W'(vshift) + DRIVE_W'(s1_off_r) - DRIVE_W'(rev_r);
  assign xsum         = s1_xr_r + X_SPAN;
  assign xoff         = xsum[FRAC_W:0];
  assign pos          = POS_W'(xoff) * POS_W'(GATE_TABLE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_drive_r <= s2_drive_nxt;
      s2_lo_r    <= (s1_xr_r < -X_SPAN);
      s2_hi_r    <= (s1_xr_r > X_SPAN);
      s2_idx_r   <= pos[POS_W-1:FRAC_W];
      s2_frac_r  <= pos[FRAC_W-1:0];
    end
  end

  // stage 3: rom reads of both neighbors
  logic [IDX_W-1:0]          idx_next;
  logic [GATE_W-1:0]         s3_e0_r, s3_e1_r;
  logic [FRAC_W-1:0]         s3_frac_r;
  logic                      s3_lo_r, s3_hi_r;
  logic signed [DRIVE_W-1:0] s3_drive_r;

  assign idx_next = (s2_idx_r == IDX_W'(GATE_TABLE_DEPTH - 1)) ? s2_idx_r
                                                                : s2_idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_e0_r    <= GATE_ROM[s2_idx_r];
      s3_e1_r    <= GATE_ROM[idx_next];
      s3_frac_r  <= s2_frac_r;
      s3_lo_r    <= s2_lo_r;
      s3_hi_r    <= s2_hi_r;
      s3_drive_r <= s2_drive_r;
    end
  end

  // stage 4: slope times fraction
  localparam int DP_W = GATE_W + 1 + FRAC_W + 1;
  logic signed [GATE_W:0]    delta;
  logic signed [DP_W-1:0]    s4_dprod_nxt, s4_dprod_r;
  logic [GATE_W-1:0]         s4_e0_r;
  logic                      s4_lo_r, s4_hi_r;
  logic signed [DRIVE_W-1:0] s4_drive_r;

  assign delta        = $signed({1'b0, s3_e1_r}) - $signed({1'b0, s3_e0_r});
  assign s4_dprod_nxt = DP_W'(delta) * DP_W'($signed({1'b0, s3_frac_r}));

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_dprod_r <= s4_dprod_nxt;
      s4_e0_r    <= s3_e0_r;
      s4_lo_r    <= s3_lo_r;
      s4_hi_r    <= s3_hi_r;
      s4_drive_r <= s3_drive_r;
    end
  end

  // stage 5: gate value with clamping outside the table
  logic signed [DP_W-1:0]    dround;
  logic signed [GATE_W+1:0]  gsum;
  logic [GATE_W-1:0]         s5_gate_nxt, s5_gate_r;
  logic signed [DRIVE_W-1:0] s5_drive_r;

  assign dround = (s4_dprod_r + DP_W'(64'sd8388608)) >>> FRAC_W;
  assign gsum   = $signed({2'b00, s4_e0_r}) + (GATE_W + 2)'(dround);

  always_comb begin
    if (s4_lo_r) begin
      s5_gate_nxt = GATE_ONE;
    end else if (s4_hi_r) begin
      s5_gate_nxt = '0;
    end else begin
      s5_gate_nxt = gsum[GATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_gate_r  <= s5_gate_nxt;
      s5_drive_r <= s4_drive_r;
    end
  end

  // stage 6: conductance times gate
  localparam int CS_W = 16 + GATE_W + 1;
  logic signed [CS_W-1:0]    s6_cs_nxt, s6_cs_r;
  logic signed [DRIVE_W-1:0] s6_drive_r;

  assign s6_cs_nxt = CS_W'(cond_r) * CS_W'($signed({1'b0, s5_gate_r}));

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_cs_r    <= s6_cs_nxt;
      s6_drive_r <= s5_drive_r;
    end
  end

  // stage 7: times driving force
  localparam int PR_W = CS_W + DRIVE_W;
  logic signed [PR_W-1:0] s7_prod_nxt, s7_prod_r;

  assign s7_prod_nxt = PR_W'(s6_cs_r) * PR_W'(s6_drive_r);

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s7_prod_r <= s7_prod_nxt;
    end
  end

  // stage 8: round, saturate, output register
  localparam int RN_W = PR_W - 16;
  logic signed [PR_W-1:0] prnd;
  logic signed [RN_W-1:0] rnd;
  logic                   ovf;
  logic signed [31:0]     cur_nxt, cur_r;
  logic                   sat_nxt, sat_r;

  assign prnd = (s7_prod_r + PR_W'(64'sd32768)) >>> 16;
  assign rnd  = prnd[RN_W-1:0];
  assign ovf  = !((&rnd[RN_W-1:31]) || !(|rnd[RN_W-1:31]));

  always_comb begin
    sat_nxt = ovf;
    if (!ovf) begin
      cur_nxt = rnd[31:0];
    end else if (rnd[RN_W-1]) begin
      cur_nxt = 32'sh8000_0000;
    end else begin
      cur_nxt = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      cur_r <= cur_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid           = v_r[NSTG-1];
  assign out_synapse_current = cur_r;
  assign out_saturated       = sat_r;

endmodule

[dv/fast_synapse_current_core_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for fast_synapse_current_core: random bursts, output stalls
// predicts each current from its own copy of the registers and sigmoid table
// depends on fsc_pkg for the register codes, reset values and table depth

module fast_synapse_current_core_tb;

  localparam int     TABLE_DEPTH  = fsc_pkg::GATE_TABLE_DEPTH;
  localparam int     DRAIN_CYCLES = 12;
  localparam int     MAX_REPORTS  = 10;
  localparam longint GATE_SPAN    = 64'sd8 <<< 20;
  localparam longint Q30_ONE      = 64'sd1 <<< 30;
  localparam longint I32_MAX      = 64'sd2147483647;
  localparam longint I32_MIN      = -(64'sd1 <<< 31);

  typedef struct packed {
    logic signed [31:0] current;
    logic               saturated;
  } synapse_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_post_voltage;
  logic signed [15:0] in_pre_voltage;
  logic signed [15:0] in_input_scale;
  logic signed [15:0] in_input_offset;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_synapse_current;
  logic               out_saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  logic signed [15:0] cond_q;
  logic signed [15:0] rev_mv;
  logic signed [15:0] slope_q;
  logic signed [15:0] thresh_mv;
  longint             gate_table [TABLE_DEPTH];

  synapse_result_t    pending_currents [$];
  synapse_result_t    head_result;
  int                 mismatches;
  int                 items_sent;
  int                 results_seen;
  int                 saturations_seen;
  int                 settings_used;
  bit                 sender_bursty;
  int                 burst_left;
  int                 ready_pos;
  logic [15:0]        ready_mask;

  fast_synapse_current_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_post_voltage     (in_post_voltage),
    .in_pre_voltage      (in_pre_voltage),
    .in_input_scale      (in_input_scale),
    .in_input_offset     (in_input_offset),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_synapse_current (out_synapse_current),
    .out_saturated       (out_saturated),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // q16 sigmoid word k, exp built from a taylor series of e^(-|x|/16) squared four times
  function automatic longint sigmoid_word(input int k);
    longint span_num;
    longint mag;
    longint g;
    longint term;
    longint acc;
    longint e;
    longint den;
    bit     upper;
    span_num = 16 * longint'(k) - 8 * longint'(TABLE_DEPTH - 1);
    upper = (span_num >= 0);
    mag = upper ? span_num : -span_num;
    g = (mag <<< 26) / longint'(TABLE_DEPTH - 1);
    term = Q30_ONE;
    acc = Q30_ONE;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * g) >>> 30) / longint'(i);
      acc = (i % 2 == 1) ? acc - term : acc + term;
    end
    e = acc;
    for (int j = 0; j < 4; j++) begin
      e = (e * e + (64'sd1 <<< 29)) >>> 30;
    end
    den = Q30_ONE + e;
    if (upper) begin
      return ((e <<< 16) + (den >>> 1)) / den;
    end
    return ((64'sd1 <<< 46) + (den >>> 1)) / den;
  endfunction

  function automatic synapse_result_t gated_current(input logic signed [15:0] post,
                                                    input logic signed [15:0] pre,
                                                    input logic signed [15:0] scale,
                                                    input logic signed [15:0] offset);
    synapse_result_t res;
    longint          sc;
    longint          off;
    longint          drive;
    longint          xr;
    longint          pos;
    longint          idx;
    longint          frac;
    longint          s;
    longint          cur;
    sc = longint'(scale);
    off = longint'(offset);
    if (sc == 0) begin
      sc = 256;
      off = 0;
    end
    drive = ((longint'(pre) * sc) >>> 8) + off - longint'(rev_mv);
    xr = longint'(slope_q) * (longint'(thresh_mv) - longint'(post));
    if (xr < -GATE_SPAN) begin
      s = 65536;
    end else if (xr > GATE_SPAN) begin
      s = 0;
    end else begin
      pos = (xr + GATE_SPAN) * longint'(TABLE_DEPTH - 1);
      idx = pos >>> 24;
      frac = pos & ((64'sd1 <<< 24) - 1);
      s = gate_table[idx];
      if (idx < TABLE_DEPTH - 1 && frac != 0) begin
        s = s + (((gate_table[idx + 1] - s) * frac + (64'sd1 <<< 23)) >>> 24);
      end
    end
    cur = (longint'(cond_q) * drive * s + (64'sd1 <<< 15)) >>> 16;
    res.saturated = 1'b0;
    if (cur > I32_MAX) begin
      cur = I32_MAX;
      res.saturated = 1'b1;
    end else if (cur < I32_MIN) begin
      cur = I32_MIN;
      res.saturated = 1'b1;
    end
    res.current = 32'(cur);
    return res;
  endfunction

  task automatic note_mismatch(input string what, input synapse_result_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected current %0d sat %0b, got current %0d sat %0b", $realtime,
               what, want.current, want.saturated, out_synapse_current, out_saturated);
    end
  endtask

  // receiver: random ready pattern, redrawn periodically, sometimes never stalling
  always @(posedge clk) begin
    if (ready_pos % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_mask = 16'hffff;
        1: ready_mask = 16'($urandom);
        2: ready_mask = 16'($urandom) & 16'($urandom) | 16'h0001;
        default: ready_mask = 16'($urandom) | 16'($urandom);
      endcase
    end
    out_ready <= ready_mask[ready_pos % 16];
    ready_pos++;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (out_saturated === 1'b1) begin
        saturations_seen++;
      end
      if (pending_currents.size() == 0) begin
        head_result = '0;
        note_mismatch("result with no item pending", head_result);
      end else begin
        head_result = pending_currents.pop_front();
        if (out_synapse_current !== head_result.current ||
            out_saturated !== head_result.saturated) begin
          note_mismatch("mismatch", head_result);
        end
      end
    end
  end

  task automatic send_item(input logic signed [15:0] post, input logic signed [15:0] pre,
                           input logic signed [15:0] scale, input logic signed [15:0] offset);
    in_valid <= 1'b1;
    in_post_voltage <= post;
    in_pre_voltage <= pre;
    in_input_scale <= scale;
    in_input_offset <= offset;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_currents.push_back(gated_current(post, pre, scale, offset));
    items_sent++;
    if (sender_bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // mostly post voltages that land inside the sigmoid table, the rest anywhere
  task automatic send_random_item();
    longint             span;
    longint             target;
    logic signed [15:0] post;
    logic signed [15:0] pre;
    logic signed [15:0] scale;
    logic signed [15:0] offset;
    post = 16'($urandom);
    if (slope_q != 0 && $urandom_range(0, 3) != 0) begin
      span = GATE_SPAN / (slope_q < 0 ? -longint'(slope_q) : longint'(slope_q)) + 2;
      if (span > 65536) begin
        span = 65536;
      end
      target = longint'(thresh_mv) + longint'($urandom_range(0, 2 * span)) - span;
      if (target > 32767) begin
        target = 32767;
      end else if (target < -32768) begin
        target = -32768;
      end
      post = 16'(target);
    end
    pre = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2048) - 1024) : 16'($urandom);
    case ($urandom_range(0, 9))
      0: scale = 16'sd0;
      1, 2, 3, 4: scale = 16'($urandom_range(0, 128) + 192);
      5, 6: scale = 16'($urandom_range(0, 1024) - 512);
      default: scale = 16'($urandom);
    endcase
    offset = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 512) - 256);
    send_item(post, pre, scale, offset);
  endtask

  task automatic wait_pipeline_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_currents.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] cond, input logic [15:0] rev,
                           input logic [15:0] slope, input logic [15:0] thr);
    fsc_pkg::cfg_reg_t order [4];
    logic [15:0]       vals [4];
    order = '{fsc_pkg::REG_CONDUCTANCE, fsc_pkg::REG_REVERSAL,
              fsc_pkg::REG_GATE_SLOPE, fsc_pkg::REG_GATE_THRESH};
    vals = '{cond, rev, slope, thr};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      case (order[i])
        fsc_pkg::REG_CONDUCTANCE: cond_q = vals[i];
        fsc_pkg::REG_REVERSAL:    rev_mv = vals[i];
        fsc_pkg::REG_GATE_SLOPE:  slope_q = vals[i];
        fsc_pkg::REG_GATE_THRESH: thresh_mv = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // reset register values: field extremes, table edges, zero scale, saturation both ways
  task automatic test_reset_defaults();
    sender_bursty = 1'b0;
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd0, 16'sd256, 16'sd256, 16'sd0);
    send_item(16'sd0, 16'sd5000, 16'sd0, 16'sd1000);
    send_item(-16'sd32768, 16'sd32767, 16'sd256, 16'sd0);
    send_item(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_item(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_item(-16'sd2048, 16'sd1000, 16'sd256, 16'sd0);
    send_item(-16'sd2049, 16'sd1000, 16'sd256, 16'sd0);
    send_item(16'sd2048, 16'sd1000, 16'sd256, 16'sd0);
    send_item(16'sd2049, 16'sd1000, 16'sd256, 16'sd0);
    send_item(16'sd1, 16'sd1000, 16'sd256, 16'sd0);
    send_item(-16'sd1, -16'sd1000, 16'sd256, 16'sd0);
    send_item(16'sd0, -16'sd1, 16'sd1, 16'sd0);
    send_item(16'sd0, 16'sd32767, -16'sd1, -16'sd1);
    send_item(16'sd100, 16'sd0, 16'sd0, -16'sd32768);
    send_item(-16'sd700, 16'sd12345, 16'sd300, 16'sd50);
    sender_bursty = 1'b1;
    send_item(16'sd1500, -16'sd12345, -16'sd300, -16'sd50);
    send_item(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_item(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    wait_pipeline_empty();
  endtask

  task automatic test_register_extremes();
    logic [15:0] corner [8][4];
    corner = '{'{16'h7fff, 16'h0000, 16'h1000, 16'h0000},
               '{16'h8000, 16'h8000, 16'h1000, 16'h7fff},
               '{16'h0000, 16'h7fff, 16'h0001, 16'h8000},
               '{16'h1000, 16'h0000, 16'h0000, 16'h0000},
               '{16'h1000, 16'h0000, 16'h8000, 16'h0000},
               '{16'h1000, 16'h03e8, 16'h7fff, 16'hec78},
               '{16'hffff, 16'hffff, 16'hffff, 16'hffff},
               '{16'h7fff, 16'h8000, 16'hf000, 16'h0100}};
    for (int c = 0; c < 8; c++) begin
      configure(corner[c][0], corner[c][1], corner[c][2], corner[c][3]);
      sender_bursty = ($urandom_range(0, 3) != 0);
      repeat (50) send_random_item();
      wait_pipeline_empty();
    end
  endtask

  task automatic test_random_settings();
    logic [15:0] slope;
    for (int p = 0; p < 8; p++) begin
      slope = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
      configure(16'($urandom), 16'($urandom), slope, 16'($urandom));
      sender_bursty = ($urandom_range(0, 3) != 0);
      repeat (150) send_random_item();
      wait_pipeline_empty();
    end
  endtask

  initial begin
    #20_000_000;
    $display("fast_synapse_current_core test failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_post_voltage <= '0;
    in_pre_voltage <= '0;
    in_input_scale <= '0;
    in_input_offset <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= fsc_pkg::REG_CONDUCTANCE;
    cfg_data <= '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      gate_table[k] = sigmoid_word(k);
    end
    cond_q = fsc_pkg::COND_RESET;
    rev_mv = fsc_pkg::REV_RESET;
    slope_q = fsc_pkg::SLOPE_RESET;
    thresh_mv = fsc_pkg::THR_RESET;
    burst_left = $urandom_range(1, 12);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_settings();
    wait_pipeline_empty();

    if (pending_currents.size() != 0) begin
      $display("%0d expected results never arrived", pending_currents.size());
      mismatches += pending_currents.size();
    end
    $display("sent %0d items under reset values and %0d register settings",
             items_sent, settings_used);
    $display("checked %0d results, %0d saturated, %0d mismatches",
             results_seen, saturations_seen, mismatches);
    if (mismatches == 0) begin
      $display("fast_synapse_current_core test passed");
    end else begin
      $display("fast_synapse_current_core test failed");
    end
    $finish;
  end

endmodule

[fast_synapse_current_core.f]
rtl/core/fsc_pkg.sv
rtl/core/fast_synapse_current_core.sv
dv/fast_synapse_current_core_tb.sv
